// File: hw/rtl/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, codes and constants for the character display nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

   localparam int COLUMNS_DEFAULT = 20;
   localparam int ROWS_DEFAULT    = 4;

   // operation codes on req_cmd
   localparam logic [2:0] CMD_PUT_CHAR    = 3'd0;
   localparam logic [2:0] CMD_PUT_CHAR_AT = 3'd1;
   localparam logic [2:0] CMD_RAW         = 3'd2;
   localparam logic [2:0] CMD_MOVE        = 3'd3;
   localparam logic [2:0] CMD_CLEAR       = 3'd4;

   localparam logic [7:0] CLEAR_BYTE = 8'h01;

   // nibble steps of one job
   localparam logic [1:0] STEP_ADDR_HI = 2'd0;
   localparam logic [1:0] STEP_ADDR_LO = 2'd1;
   localparam logic [1:0] STEP_DATA_HI = 2'd2;
   localparam logic [1:0] STEP_DATA_LO = 2'd3;

   // one job: optional set-address byte, then optional data/command byte
   typedef struct packed {
      logic       has_addr;
      logic [7:0] addr;
      logic       has_data;
      logic       rs;
      logic [7:0] data;
   } job_type;

   // DDRAM start address of a row counted from 0
   function automatic logic [7:0] row_base(input logic [1:0] row_idx);
      logic [7:0] base;
      case (row_idx)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'hC0;
         2'd2:    base = 8'h94;
         default: base = 8'hD4;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Accepts items, tracks the cursor and turns each item into at most one job.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_front #(
   parameter int COLUMNS = clnw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = clnw_pkg::ROWS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire  [2:0]           req_cmd,
   input  wire  [7:0]           req_data_byte,
   input  wire  [2:0]           req_row,
   input  wire  [4:0]           req_col,
   input  wire                  queue_full,
   output logic                 job_push,
   output clnw_pkg::job_type    job
);
   import clnw_pkg::*;

   localparam logic [4:0] LAST_COL = 5'(COLUMNS - 1);
   localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);
   localparam logic [2:0] ROW_MAX  = 3'(ROWS);

   // cursor kept as row/column; the end-of-screen position behaves as 0
   logic [1:0] cur_row_ff, cur_row_in;
   logic [4:0] cur_col_ff, cur_col_in;

   logic       accept;
   logic       row_ok;
   logic [7:0] goto_addr;
   logic       produce;

   assign accept    = push && !queue_full;
   assign row_ok    = (req_row != 3'd0) && (req_row <= ROW_MAX);
   assign goto_addr = row_base(2'(req_row - 3'd1)) + {3'b000, req_col} - 8'd1;

   always_comb begin
      job        = '0;
      produce    = 1'b0;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      case (req_cmd)
         CMD_PUT_CHAR: begin
            produce      = 1'b1;
            job.has_addr = (cur_col_ff == 5'd0);
            job.addr     = row_base(cur_row_ff);
            job.has_data = 1'b1;
            job.rs       = 1'b1;
            job.data     = req_data_byte;
            if (cur_col_ff == LAST_COL) begin
               cur_col_in = 5'd0;
               cur_row_in = (cur_row_ff == LAST_ROW) ? 2'd0 : cur_row_ff + 2'd1;
            end else begin
               cur_col_in = cur_col_ff + 5'd1;
            end
         end
         CMD_PUT_CHAR_AT: begin
            produce      = 1'b1;
            job.has_addr = row_ok;
            job.addr     = goto_addr;
            job.has_data = 1'b1;
            job.rs       = 1'b1;
            job.data     = req_data_byte;
         end
         CMD_RAW: begin
            produce      = 1'b1;
            job.has_data = 1'b1;
            job.data     = req_data_byte;
         end
         CMD_MOVE: begin
            produce      = row_ok;
            job.has_addr = 1'b1;
            job.addr     = goto_addr;
         end
         CMD_CLEAR: begin
            produce      = 1'b1;
            job.has_data = 1'b1;
            job.data     = CLEAR_BYTE;
            cur_row_in   = 2'd0;
            cur_col_in   = 5'd0;
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   assign job_push = accept && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= 2'd0;
         cur_col_ff <= 5'd0;
      end else if (accept) begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/clnw_job_fifo.sv
// ----------------------------------------------------------------------------
// clnw_job_fifo
// Two-entry job queue between the front and the nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_job_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_en,
   input  wire clnw_pkg::job_type wr_job,
   output logic                 full,
   input  wire                  rd_en,
   output logic                 not_empty,
   output clnw_pkg::job_type    rd_job
);
   import clnw_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;
   assign rd_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Nibble sequencer: splits each job into nibbles into the result register,
// one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_avail,
   input  wire clnw_pkg::job_type job_in,
   output logic                 job_take,
   output logic                 empty,
   input  wire                  pop,
   output logic                 rsp_reg_select,
   output logic [3:0]           rsp_nibble,
   output logic                 rsp_last
);
   import clnw_pkg::*;

   job_type    job_ff;
   logic       busy_ff, busy_in;
   logic [1:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_rs_ff;
   logic [3:0] out_nib_ff;
   logic       out_last_ff;

   logic       advance;
   logic       is_last;
   logic       cur_rs;
   logic [3:0] cur_nib;

   assign advance = busy_ff && (!out_valid_ff || pop);
   assign is_last = (step_ff == STEP_DATA_LO) ||
                    ((step_ff == STEP_ADDR_LO) && !job_ff.has_data);
   assign job_take = job_avail && (!busy_ff || (advance && is_last));

   always_comb begin
      cur_rs  = 1'b0;
      cur_nib = job_ff.addr[7:4];
      case (step_ff)
         STEP_ADDR_HI: cur_nib = job_ff.addr[7:4];
         STEP_ADDR_LO: cur_nib = job_ff.addr[3:0];
         STEP_DATA_HI: begin
            cur_rs  = job_ff.rs;
            cur_nib = job_ff.data[7:4];
         end
         STEP_DATA_LO: begin
            cur_rs  = job_ff.rs;
            cur_nib = job_ff.data[3:0];
         end
         default: cur_nib = job_ff.addr[7:4];
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (job_take) begin
         busy_in = 1'b1;
         step_in = job_in.has_addr ? STEP_ADDR_HI : STEP_DATA_HI;
      end else if (advance) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
      out_valid_in = advance || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         job_ff <= job_in;
      end
      if (advance) begin
         out_rs_ff   <= cur_rs;
         out_nib_ff  <= cur_nib;
         out_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_ADDR_HI;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/char_lcd_nibble_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Turns display operations into 4-bit bus nibbles for a 20x4 character LCD.
//
// Input side is a queue: present an item and raise push; it is taken on a
// clock edge with push high and full low. Each item yields up to four
// nibbles (set-address byte and/or data/command byte, high half first);
// rsp_last marks the final nibble of an item. Items that yield nothing
// (move cursor to an invalid row, unused codes) are taken and dropped.
// Result side is a queue: while empty is low the oldest nibble is on the
// rsp_ ports and is taken on an edge with pop high.
// An item goes through the job queue and the job register before its first
// nibble reaches the result register. The sequencer gives one nibble per
// cycle while the receiver keeps popping; a two-job queue lets new items be
// accepted while the sequencer works. If the receiver stops popping, the
// sequencer holds, the job queue fills and full rises.
// Reset (synchronous) clears the cursor to row 1 column 1 and empties all
// queues. The enable hold time does not alter the nibble stream here.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer_top #(
   parameter int COLUMNS = clnw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = clnw_pkg::ROWS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [2:0]  req_cmd,
   input  wire  [7:0]  req_data_byte,
   input  wire  [2:0]  req_row,
   input  wire  [4:0]  req_col,
   output logic        empty,
   input  wire         pop,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_last,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);
   import clnw_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    front_push;
   logic    queue_full;
   logic    queue_avail;
   logic    back_take;

   assign full = queue_full;

   clnw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_row       (req_row),
      .req_col       (req_col),
      .queue_full    (queue_full),
      .job_push      (front_push),
      .job           (front_job)
   );

   clnw_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (front_push),
      .wr_job    (front_job),
      .full      (queue_full),
      .rd_en     (back_take),
      .not_empty (queue_avail),
      .rd_job    (queue_job)
   );

   clnw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_avail      (queue_avail),
      .job_in         (queue_job),
      .job_take       (back_take),
      .empty          (empty),
      .pop            (pop),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
